// File: src/dq_pkg.sv
// Package for the double-ended queue: sizes, operation and status codes, row control.
package dq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ROW_HOLD,
    ROW_PUSH_FRONT,
    ROW_PUSH_BACK,
    ROW_POP_FRONT,
    ROW_ROTATE
  } row_op_t;

  typedef struct packed {
    row_op_t          op;
    logic [CNT_W-1:0] count;
  } row_ctrl_t;

endpackage

// File: src/double_ended_queue.sv
// Double-ended queue built as a row of shifting cells, front at cell zero.
// Push and pop: one item per cycle while not busy, result strobed on the cycle after accept.
// List: busy while it emits one result per entry, one per cycle starting the cycle after
//   the first busy cycle; a list of an empty queue answers like a pop.
// Synchronous reset empties the queue and clears control; cell contents are not reset.
// Results cannot be held off by the receiver.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        operation,
  input  logic signed [dq_pkg::DATA_W-1:0]  value,
  output logic                              valid,
  output logic [1:0]                        status,
  output logic signed [dq_pkg::DATA_W-1:0]  data,
  output logic                              last
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  list_idx, list_idx_next;
  logic              valid_next;
  logic [1:0]        status_next;
  logic signed [DATA_W-1:0] data_next;
  logic              last_next;

  row_ctrl_t         ctrl;
  row_op_t           row_op;
  logic signed [DATA_W-1:0] cells [CAPACITY];
  logic signed [DATA_W-1:0] back_data;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              list_end;

  assign busy     = (state == S_LIST);
  assign accept   = start && !busy;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign list_end = (CNT_W'(list_idx) == count - CNT_W'(1));

  assign ctrl.op    = row_op;
  assign ctrl.count = count;

  // back entry picked out of the row
  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == count - CNT_W'(1)) back_data = back_data | cells[i];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    list_idx_next = list_idx;
    row_op        = ROW_HOLD;
    valid_next    = 1'b0;
    status_next   = ST_OK;
    data_next     = '0;
    last_next     = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              valid_next = 1'b1;
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                row_op     = (operation == OP_PUSH_FRONT) ? ROW_PUSH_FRONT : ROW_PUSH_BACK;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              valid_next = 1'b1;
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                data_next  = cells[0];
                row_op     = ROW_POP_FRONT;
                count_next = count - CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              valid_next = 1'b1;
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                data_next  = back_data;
                count_next = count - CNT_W'(1);
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                valid_next  = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next    = S_LIST;
                list_idx_next = '0;
              end
            end
            default: begin
              valid_next = 1'b0;
            end
          endcase
        end
      end
      S_LIST: begin
        // emit the front and rotate; after count steps the row is back in order
        valid_next    = 1'b1;
        data_next     = cells[0];
        last_next     = list_end;
        row_op        = ROW_ROTATE;
        list_idx_next = list_idx + IDX_W'(1);
        if (list_end) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_next
      assign right_in = cells[g+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .index      (IDX_W'(g)),
      .ctrl       (ctrl),
      .in_value   (value),
      .from_left  (left_in),
      .from_right (right_in),
      .wrap_data  (cells[0]),
      .data       (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      list_idx <= '0;
      valid    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      valid    <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    data   <= data_next;
    last   <= last_next;
  end

endmodule

// File: src/dq_cell.sv
// One storage cell of the queue row; takes data from a neighbor, the front cell or the input.
module dq_cell (
  input  logic                              clk,
  input  logic [dq_pkg::IDX_W-1:0]          index,
  input  dq_pkg::row_ctrl_t                 ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0]  in_value,
  input  logic signed [dq_pkg::DATA_W-1:0]  from_left,
  input  logic signed [dq_pkg::DATA_W-1:0]  from_right,
  input  logic signed [dq_pkg::DATA_W-1:0]  wrap_data,
  output logic signed [dq_pkg::DATA_W-1:0]  data
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] data_next;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         tail;

  assign pos  = CNT_W'(index);
  assign tail = ctrl.count - CNT_W'(1);

  always_comb begin
    data_next = data;
    case (ctrl.op)
      ROW_PUSH_FRONT: begin
        data_next = (index == '0) ? in_value : from_left;
      end
      ROW_PUSH_BACK: begin
        if (pos == ctrl.count) data_next = in_value;
      end
      ROW_POP_FRONT: begin
        data_next = from_right;
      end
      ROW_ROTATE: begin
        // front item wraps to the back end of the occupied span
        if (pos < tail) data_next = from_right;
        else if (pos == tail) data_next = wrap_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: bench/dq_checker.sv
// Checker for the double-ended queue: predicts results per accepted item and compares them.
`timescale 1ns / 1ps

module dq_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [2:0]                        operation,
  input  logic signed [dq_pkg::DATA_W-1:0]  value,
  input  logic                              valid,
  input  logic [1:0]                        status,
  input  logic signed [dq_pkg::DATA_W-1:0]  data,
  input  logic                              last,
  output int                                mismatches,
  output int                                pending
);
  import dq_pkg::*;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } deque_result_t;

  deque_result_t            expected_results[$];
  deque_result_t            oldest;
  logic signed [DATA_W-1:0] model_slots [CAPACITY];
  int                       model_front;
  int                       model_count;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int slot_at(input int offset);
    return (model_front + offset) % CAPACITY;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_result(input logic [1:0] st, input logic signed [DATA_W-1:0] d,
                              input logic lst);
    deque_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    expected_results.push_back(r);
  endtask

  task automatic predict_deque(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_count >= CAPACITY) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            model_front = slot_at(CAPACITY - 1);
            model_slots[model_front] = val;
          end else begin
            model_slots[slot_at(model_count)] = val;
          end
          model_count++;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (model_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else if (op == OP_POP_FRONT) begin
          queue_result(ST_OK, model_slots[model_front], 1'b1);
          model_front = slot_at(1);
          model_count--;
        end else begin
          queue_result(ST_OK, model_slots[slot_at(model_count - 1)], 1'b1);
          model_count--;
        end
      end
      OP_LIST: begin
        if (model_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < model_count; i++)
            queue_result(ST_OK, model_slots[slot_at(i)], (i == model_count - 1));
        end
      end
      default: ;  // unused codes: no result, no state change
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      model_front = 0;
      model_count = 0;
      expected_results.delete();
    end else begin
      // predict first so a result and a new item on the same edge stay in order
      if (start && !busy)
        predict_deque(operation, value);
      if (valid !== 1'b0 && valid !== 1'b1) begin
        report_mismatch("result strobe unknown");
      end else if (valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          oldest = expected_results.pop_front();
          if (status !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, oldest.status));
          if (data !== oldest.data)
            report_mismatch($sformatf("data %0d, expected %0d", data, oldest.data));
          if (last !== oldest.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, oldest.last));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: bench/tb_top.sv
// Testbench top for the double-ended queue: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 80;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [2:0]               operation;
  logic signed [DATA_W-1:0] value;
  logic                     valid;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;
  int                       mismatches;
  int                       pending;
  int                       cycle_count;
  logic                     burst;

  double_ended_queue dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .valid     (valid),
    .status    (status),
    .data      (data),
    .last      (last)
  );

  dq_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .value      (value),
    .valid      (valid),
    .status     (status),
    .data       (data),
    .last       (last),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // start stays high when the next item follows with no gap
  task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every predicted result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic int pick_gap();
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 mixes
  function automatic logic [2:0] pick_op(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 45) return OP_PUSH_FRONT;
        if (r < 85) return OP_PUSH_BACK;
        if (r < 90) return OP_POP_FRONT;
        if (r < 94) return OP_POP_BACK;
        if (r < 98) return OP_LIST;
      end
      1: begin
        if (r < 7)  return OP_PUSH_FRONT;
        if (r < 15) return OP_PUSH_BACK;
        if (r < 50) return OP_POP_FRONT;
        if (r < 85) return OP_POP_BACK;
        if (r < 95) return OP_LIST;
      end
      default: begin
        if (r < 25) return OP_PUSH_FRONT;
        if (r < 50) return OP_PUSH_BACK;
        if (r < 68) return OP_POP_FRONT;
        if (r < 86) return OP_POP_BACK;
        if (r < 97) return OP_LIST;
      end
    endcase
    return 3'($urandom_range(5, 7));
  endfunction

  initial begin
    int         sent;
    int         mode;
    int         mode_left;
    logic [2:0] op;

    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= OP_PUSH_FRONT;
    value     <= '0;
    burst     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue corners, the extremes through both ends, unused codes, then a fill past capacity
    send_item(OP_LIST, '0, pick_gap());
    send_item(OP_POP_FRONT, '0, pick_gap());
    send_item(OP_POP_BACK, '1, pick_gap());
    send_item(OP_PUSH_FRONT, 32'sh7fffffff, pick_gap());
    send_item(OP_PUSH_BACK, 32'sh80000000, pick_gap());
    send_item(OP_LIST, '0, pick_gap());
    send_item(OP_POP_BACK, '0, pick_gap());
    send_item(OP_POP_FRONT, '0, pick_gap());  // takes the only entry
    send_item(3'd5, $urandom, pick_gap());
    send_item(3'd6, $urandom, pick_gap());
    send_item(3'd7, '1, pick_gap());
    for (int i = 0; i < CAPACITY; i++)
      send_item(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, pick_gap());
    send_item(OP_PUSH_FRONT, 32'sh7fffffff, pick_gap());
    send_item(OP_PUSH_BACK, 32'sh80000000, pick_gap());
    send_item(OP_LIST, '0, pick_gap());
    wait_drained();

    sent      = 0;
    mode      = 0;
    mode_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 30);
        burst     = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      op = pick_op(mode);
      send_item(op, pick_value(), pick_gap());
      if (op <= OP_LIST)
        sent++;
      if (sent == RANDOM_ITEMS / 2 && op <= OP_LIST)
        wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
